[rtl/core/jsu_pkg.sv]
// shared types, codes and character constants of the json string unescaper
package jsu_pkg;

	typedef enum logic [1:0] {
		MODE_PLAIN   = 2'd0,
		MODE_ESCAPE  = 2'd1,
		MODE_UNICODE = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_DONE  = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_END_STRING  = 3'd0,
		ERR_END_ESCAPE  = 3'd1,
		ERR_END_UNICODE = 3'd2,
		ERR_BAD_HEX     = 3'd3,
		ERR_BAD_ESCAPE  = 3'd4
	} err_t;

	localparam int unsigned MAX_RESULTS = 3;

	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_B         = 8'h62;
	localparam logic [7:0] CH_F         = 8'h66;
	localparam logic [7:0] CH_N         = 8'h6E;
	localparam logic [7:0] CH_R         = 8'h72;
	localparam logic [7:0] CH_T         = 8'h74;
	localparam logic [7:0] CH_U         = 8'h75;
	localparam logic [7:0] CH_0         = 8'h30;
	localparam logic [7:0] CH_LC_A      = 8'h61;
	localparam logic [7:0] CH_UC_A      = 8'h41;

	localparam logic [7:0] CTL_BS = 8'h08;
	localparam logic [7:0] CTL_FF = 8'h0C;
	localparam logic [7:0] CTL_LF = 8'h0A;
	localparam logic [7:0] CTL_CR = 8'h0D;
	localparam logic [7:0] CTL_HT = 8'h09;

	localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
	localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
	localparam logic [7:0]  UTF8_CONT  = 8'h80;
	localparam logic [7:0]  UTF8_MASK6 = 8'h3F;
	localparam logic [15:0] CP_ONE_BYTE_LIM = 16'h0080;
	localparam logic [15:0] CP_TWO_BYTE_LIM = 16'h0800;

	typedef struct packed {
		kind_t      kind;
		err_t       code;
		logic [7:0] data;
	} result_t;

	typedef struct packed {
		mode_t       mode;
		logic [1:0]  hex_cnt;
		logic [15:0] cp;
	} state_t;

	// decoder outcome for one input beat
	typedef struct packed {
		state_t                        nxt;
		logic [1:0]                    cnt;
		result_t [MAX_RESULTS-1:0]     res;
	} dec_t;

endpackage

[rtl/core/jsu_if.sv]
// valid/ready channel interfaces for raw input and decoded results
interface jsu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_input;

	modport source (output valid, output data_byte, output end_of_input, input ready);
	modport sink (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface jsu_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] result_kind;
	logic [2:0] error_code;
	logic [7:0] out_byte;
	logic       last;

	modport source (output valid, output result_kind, output error_code, output out_byte,
		output last, input ready);
	modport sink (input valid, input result_kind, input error_code, input out_byte,
		input last, output ready);
endinterface

[rtl/core/jsu_decode.sv]
// combinational decode of one raw byte against the current unescape state
module jsu_decode
	import jsu_pkg::*;
(
	input  state_t     cur,
	input  logic [7:0] data_byte,
	input  logic       end_of_input,
	output dec_t       dec
);

	logic        hex_ok;
	logic [3:0]  hex_val;
	logic [15:0] cp_new;
	state_t      cleared;

	always_comb begin
		hex_ok  = 1'b1;
		hex_val = '0;
		if (data_byte >= CH_0 && data_byte <= 8'h39) begin
			hex_val = 4'(data_byte - CH_0);
		end else if (data_byte >= CH_LC_A && data_byte <= 8'h66) begin
			hex_val = 4'(data_byte - CH_LC_A + 8'd10);
		end else if (data_byte >= CH_UC_A && data_byte <= 8'h46) begin
			hex_val = 4'(data_byte - CH_UC_A + 8'd10);
		end else begin
			hex_ok = 1'b0;
		end
	end

	assign cp_new = {cur.cp[11:0], hex_val};

	always_comb begin
		cleared = '{mode: MODE_PLAIN, hex_cnt: 2'd0, cp: 16'd0};
		dec     = '0;
		dec.nxt = cur;
		dec.cnt = 2'd0;
		for (int i = 0; i < MAX_RESULTS; i++) begin
			dec.res[i] = '{kind: KIND_BYTE, code: ERR_END_STRING, data: 8'd0};
		end

		if (end_of_input) begin
			dec.cnt         = 2'd1;
			dec.res[0].kind = KIND_ERROR;
			unique case (cur.mode)
				MODE_ESCAPE:  dec.res[0].code = ERR_END_ESCAPE;
				MODE_UNICODE: dec.res[0].code = ERR_END_UNICODE;
				default:      dec.res[0].code = ERR_END_STRING;
			endcase
			dec.nxt = cleared;
		end else begin
			unique case (cur.mode)
				MODE_ESCAPE: begin
					dec.cnt      = 2'd1;
					dec.nxt.mode = MODE_PLAIN;
					case (data_byte)
						CH_QUOTE:     dec.res[0].data = CH_QUOTE;
						CH_BACKSLASH: dec.res[0].data = CH_BACKSLASH;
						CH_SLASH:     dec.res[0].data = CH_SLASH;
						CH_B:         dec.res[0].data = CTL_BS;
						CH_F:         dec.res[0].data = CTL_FF;
						CH_N:         dec.res[0].data = CTL_LF;
						CH_R:         dec.res[0].data = CTL_CR;
						CH_T:         dec.res[0].data = CTL_HT;
						CH_U: begin
							dec.cnt = 2'd0;
							dec.nxt = '{mode: MODE_UNICODE, hex_cnt: 2'd0, cp: 16'd0};
						end
						default: begin
							dec.res[0].kind = KIND_ERROR;
							dec.res[0].code = ERR_BAD_ESCAPE;
							dec.nxt         = cleared;
						end
					endcase
				end
				MODE_UNICODE: begin
					if (!hex_ok) begin
						dec.cnt         = 2'd1;
						dec.res[0].kind = KIND_ERROR;
						dec.res[0].code = ERR_BAD_HEX;
						dec.nxt         = cleared;
					end else if (cur.hex_cnt == 2'd3) begin
						dec.nxt = cleared;
						if (cp_new < CP_ONE_BYTE_LIM) begin
							dec.cnt         = 2'd1;
							dec.res[0].data = cp_new[7:0];
						end else if (cp_new < CP_TWO_BYTE_LIM) begin
							dec.cnt         = 2'd2;
							dec.res[0].data = UTF8_LEAD2 | {3'd0, cp_new[10:6]};
							dec.res[1].data = UTF8_CONT | (cp_new[7:0] & UTF8_MASK6);
						end else begin
							dec.cnt         = 2'd3;
							dec.res[0].data = UTF8_LEAD3 | {4'd0, cp_new[15:12]};
							dec.res[1].data = UTF8_CONT | (cp_new[13:6] & UTF8_MASK6);
							dec.res[2].data = UTF8_CONT | (cp_new[7:0] & UTF8_MASK6);
						end
					end else begin
						dec.nxt.hex_cnt = cur.hex_cnt + 2'd1;
						dec.nxt.cp      = cp_new;
					end
				end
				default: begin
					if (data_byte == CH_QUOTE) begin
						dec.cnt         = 2'd1;
						dec.res[0].kind = KIND_DONE;
						dec.nxt         = cleared;
					end else if (data_byte == CH_BACKSLASH) begin
						dec.nxt.mode = MODE_ESCAPE;
					end else begin
						dec.cnt         = 2'd1;
						dec.res[0].data = data_byte;
						dec.nxt.mode    = MODE_PLAIN;
					end
				end
			endcase
		end
	end

endmodule

[rtl/core/json_string_unescape_top.sv]
// top level of the streaming json string body unescaper
//
// usage
//   raw    : one beat per byte of the string body after the opening quote,
//            or a beat with end_of_input set when the source runs dry
//   result : decoded bytes (kind 0), string complete (kind 1) or an error
//            (kind 2 with error_code); last marks the final beat caused by
//            one raw beat
// decode and flow
//   a raw beat is decoded in the cycle it is taken; its results are registered
//   and appear on result in the next cycle. while result.ready is high, plain
//   bytes and simple escapes run at one beat per cycle; a \u escape gives one to
//   three result beats sent one per cycle from a small buffer. raw is held off
//   while a beat short of the group's last waits, so a two- or three-beat group
//   stalls raw. backslash, the u and the first three hex digits give no result.
// reset
//   arst_n clears the decode state to plain mode and empties the buffer
// stall
//   while result.ready is low the buffered beat holds; raw.ready stays high
//   only when the buffer is empty or its last beat leaves this cycle
module json_string_unescape_top
	import jsu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	jsu_in_if.sink      raw,
	jsu_out_if.source   result
);

	// decode state that carries from beat to beat
	state_t  state_q;

	// result buffer: up to three beats from one raw beat
	result_t [MAX_RESULTS-1:0] res_q;
	logic [1:0] cnt_q;
	logic [1:0] idx_q;

	dec_t dec;
	logic in_fire;
	logic out_fire;
	logic out_last;

	jsu_decode u_decode (
		.cur          (state_q),
		.data_byte    (raw.data_byte),
		.end_of_input (raw.end_of_input),
		.dec          (dec)
	);

	// the beat being shown is the last of its group
	assign out_last = (idx_q == (cnt_q - 2'd1));

	assign result.valid       = (cnt_q != 2'd0);
	assign result.result_kind = res_q[idx_q].kind;
	assign result.error_code  = res_q[idx_q].code;
	assign result.out_byte    = res_q[idx_q].data;
	assign result.last        = out_last;

	assign out_fire  = result.valid && result.ready;
	// new raw beat fits when the buffer is empty or drains this cycle
	assign raw.ready = (cnt_q == 2'd0) || (result.ready && out_last);
	assign in_fire   = raw.valid && raw.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{mode: MODE_PLAIN, hex_cnt: 2'd0, cp: 16'd0};
			cnt_q   <= 2'd0;
			idx_q   <= 2'd0;
		end else begin
			if (in_fire) begin
				state_q <= dec.nxt;
			end
			if (in_fire && dec.cnt != 2'd0) begin
				// load a fresh group of results
				cnt_q <= dec.cnt;
				idx_q <= 2'd0;
			end else if (out_fire) begin
				if (out_last) begin
					cnt_q <= 2'd0;
					idx_q <= 2'd0;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
		end
	end

	// payload of the buffer, no reset needed
	always_ff @(posedge clk) begin
		if (in_fire && dec.cnt != 2'd0) begin
			res_q <= dec.res;
		end
	end

	// pointer never runs past the group
	a_idx_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd0 |-> idx_q < cnt_q)
		else $error("result index beyond group");

	// hex digits are only counted inside a \u escape
	a_hex_only_unicode: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.hex_cnt != 2'd0 |-> state_q.mode == MODE_UNICODE)
		else $error("hex count outside unicode mode");

	// end of input always answers with an error beat next cycle
	a_end_gives_error: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && raw.end_of_input |=>
			result.valid && result.result_kind == KIND_ERROR && result.last)
		else $error("end of input without error beat");

	// raw is only taken over a pending group when its last beat leaves
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && cnt_q != 2'd0 |-> out_fire && out_last)
		else $error("result group overwritten");

endmodule
